FILE: hdl/tfn_pkg.sv
package tfn_pkg;

   // Input and result field widths.
   localparam int CoordWidth = 16;
   localparam int EdgeWidth  = 17;
   localparam int CrossWidth = 35;
   localparam int MagWidth   = 34;
   localparam int SumWidth   = 70;
   localparam int RootWidth  = 35;
   localparam int NormWidth  = 16;
   localparam int EpsWidth   = 16;

   // Square root runs one result bit per stage.
   localparam int RootSteps = RootWidth;

   // Division: quotient up to 16384 needs 15 bits, one bit per stage.
   localparam int QuotWidth = 15;
   localparam int DivSteps  = QuotWidth;
   localparam int NumWidth  = MagWidth + 14;

   localparam logic [NormWidth-1:0] NormOne = NormWidth'(16384);

   // Configuration register indexes.
   localparam int CsrAddrWidth = 1;
   typedef enum logic [CsrAddrWidth-1:0] {
      CSR_EPSILON = 1'b0
   } csr_index_type;

   localparam logic [EpsWidth-1:0] EpsilonReset = EpsWidth'(1);

   // One triangle.
   typedef struct packed {
      logic signed [CoordWidth-1:0] a_x;
      logic signed [CoordWidth-1:0] a_y;
      logic signed [CoordWidth-1:0] a_z;
      logic signed [CoordWidth-1:0] b_x;
      logic signed [CoordWidth-1:0] b_y;
      logic signed [CoordWidth-1:0] b_z;
      logic signed [CoordWidth-1:0] c_x;
      logic signed [CoordWidth-1:0] c_y;
      logic signed [CoordWidth-1:0] c_z;
   } req_item_type;

   // One unit normal.
   typedef struct packed {
      logic signed [NormWidth-1:0] norm_x;
      logic signed [NormWidth-1:0] norm_y;
      logic signed [NormWidth-1:0] norm_z;
      logic                        degenerate;
   } rsp_item_type;

   // Pipeline control: advance enable shared by all stages.
   typedef struct packed {
      logic advance;
   } pipe_ctrl_type;

endpackage

FILE: hdl/tfn_if.sv
interface tfn_req_if;
   import tfn_pkg::*;
   logic         valid;
   logic         ready;
   req_item_type item;
   modport source (output valid, output item, input ready);
   modport sink (input valid, input item, output ready);
endinterface

interface tfn_rsp_if;
   import tfn_pkg::*;
   logic         valid;
   logic         ready;
   rsp_item_type item;
   modport source (output valid, output item, input ready);
   modport sink (input valid, input item, output ready);
endinterface

FILE: hdl/tfn_cross.sv
module tfn_cross (
   input  logic                                      clock,
   input  tfn_pkg::pipe_ctrl_type                    ctrl,
   input  tfn_pkg::req_item_type                     item,
   output logic signed [tfn_pkg::CrossWidth-1:0]     cross_x,
   output logic signed [tfn_pkg::CrossWidth-1:0]     cross_y,
   output logic signed [tfn_pkg::CrossWidth-1:0]     cross_z
);
   import tfn_pkg::*;

   logic signed [EdgeWidth-1:0] e1x_ff, e1y_ff, e1z_ff, e2x_ff, e2y_ff, e2z_ff;
   logic signed [EdgeWidth-1:0] e1x_in, e1y_in, e1z_in, e2x_in, e2y_in, e2z_in;
   logic signed [2*EdgeWidth-1:0] p0_ff, p1_ff, p2_ff, p3_ff, p4_ff, p5_ff;
   logic signed [2*EdgeWidth-1:0] p0_in, p1_in, p2_in, p3_in, p4_in, p5_in;
   logic signed [CrossWidth-1:0] cx_ff, cy_ff, cz_ff, cx_in, cy_in, cz_in;

   // Edges from the first corner.
   always_comb begin
      e1x_in = EdgeWidth'(item.b_x) - EdgeWidth'(item.a_x);
      e1y_in = EdgeWidth'(item.b_y) - EdgeWidth'(item.a_y);
      e1z_in = EdgeWidth'(item.b_z) - EdgeWidth'(item.a_z);
      e2x_in = EdgeWidth'(item.c_x) - EdgeWidth'(item.a_x);
      e2y_in = EdgeWidth'(item.c_y) - EdgeWidth'(item.a_y);
      e2z_in = EdgeWidth'(item.c_z) - EdgeWidth'(item.a_z);
   end

   // Six products, registered before the differences.
   always_comb begin
      p0_in = e1y_ff * e2z_ff;
      p1_in = e1z_ff * e2y_ff;
      p2_in = e1z_ff * e2x_ff;
      p3_in = e1x_ff * e2z_ff;
      p4_in = e1x_ff * e2y_ff;
      p5_in = e1y_ff * e2x_ff;
      cx_in = CrossWidth'(p0_ff) - CrossWidth'(p1_ff);
      cy_in = CrossWidth'(p2_ff) - CrossWidth'(p3_ff);
      cz_in = CrossWidth'(p4_ff) - CrossWidth'(p5_ff);
   end

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         e1x_ff <= e1x_in; e1y_ff <= e1y_in; e1z_ff <= e1z_in;
         e2x_ff <= e2x_in; e2y_ff <= e2y_in; e2z_ff <= e2z_in;
         p0_ff <= p0_in; p1_ff <= p1_in; p2_ff <= p2_in;
         p3_ff <= p3_in; p4_ff <= p4_in; p5_ff <= p5_in;
         cx_ff <= cx_in; cy_ff <= cy_in; cz_ff <= cz_in;
      end
   end

   assign cross_x = cx_ff;
   assign cross_y = cy_ff;
   assign cross_z = cz_ff;
endmodule

FILE: hdl/tfn_sqrt.sv
module tfn_sqrt (
   input  logic                                  clock,
   input  tfn_pkg::pipe_ctrl_type                ctrl,
   input  logic signed [tfn_pkg::CrossWidth-1:0] cross_x,
   input  logic signed [tfn_pkg::CrossWidth-1:0] cross_y,
   input  logic signed [tfn_pkg::CrossWidth-1:0] cross_z,
   output logic [tfn_pkg::RootWidth-1:0]         root,
   output logic [tfn_pkg::MagWidth-1:0]          mag_x,
   output logic [tfn_pkg::MagWidth-1:0]          mag_y,
   output logic [tfn_pkg::MagWidth-1:0]          mag_z,
   output logic [2:0]                            neg
);
   import tfn_pkg::*;

   localparam int HalfMag = MagWidth / 2;

   logic [MagWidth-1:0] m_ff [3];
   logic [MagWidth-1:0] m_in [3];
   logic [2:0]          s_ff [4];
   logic [2:0]          s_in;
   logic [MagWidth-1:0] hold_ff [3][3];
   // Squares built from half-width partial products over two stages.
   logic [MagWidth-1:0] pl_ff [3], pl_in [3];
   logic [MagWidth:0]   pm_ff [3], pm_in [3];
   logic [MagWidth-1:0] ph_ff [3], ph_in [3];
   logic [SumWidth-1:0] sq_ff [3], sq_in [3];
   logic [SumWidth-1:0] sum_ff, sum_in;

   // Square root: rem, root and carried magnitudes per stage.
   logic [SumWidth-1:0] rem_ff [RootSteps+1];
   logic [RootWidth-1:0] rt_ff [RootSteps+1];
   logic [MagWidth-1:0] rm_ff [RootSteps+1][3];
   logic [2:0]          rs_ff [RootSteps+1];

   always_comb begin
      m_in[0] = MagWidth'(cross_x[CrossWidth-1] ? -cross_x : cross_x);
      m_in[1] = MagWidth'(cross_y[CrossWidth-1] ? -cross_y : cross_y);
      m_in[2] = MagWidth'(cross_z[CrossWidth-1] ? -cross_z : cross_z);
      s_in = {cross_z[CrossWidth-1], cross_y[CrossWidth-1], cross_x[CrossWidth-1]};
      for (int k = 0; k < 3; k++) begin
         pl_in[k] = m_ff[k][HalfMag-1:0] * m_ff[k][HalfMag-1:0];
         pm_in[k] = (MagWidth+1)'(m_ff[k][HalfMag-1:0] * m_ff[k][MagWidth-1:HalfMag]) << 1;
         ph_in[k] = m_ff[k][MagWidth-1:HalfMag] * m_ff[k][MagWidth-1:HalfMag];
         sq_in[k] = SumWidth'(pl_ff[k]) + (SumWidth'(pm_ff[k]) << HalfMag)
                  + (SumWidth'(ph_ff[k]) << MagWidth);
      end
      sum_in = sq_ff[0] + sq_ff[1] + sq_ff[2];
   end

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         m_ff <= m_in;
         s_ff[0] <= s_in;
         pl_ff <= pl_in; pm_ff <= pm_in; ph_ff <= ph_in;
         hold_ff[0] <= m_ff;
         s_ff[1] <= s_ff[0];
         sq_ff <= sq_in;
         hold_ff[1] <= hold_ff[0];
         s_ff[2] <= s_ff[1];
         sum_ff <= sum_in;
         hold_ff[2] <= hold_ff[1];
         s_ff[3] <= s_ff[2];
      end
   end

   always_comb begin
      rem_ff[0] = sum_ff;
      rt_ff[0]  = '0;
      rm_ff[0]  = hold_ff[2];
      rs_ff[0]  = s_ff[3];
   end

   // One root bit per stage: try root | bit against the remaining square.
   for (genvar g = 0; g < RootSteps; g++) begin : g_root
      localparam int Bit = RootSteps - 1 - g;
      logic [SumWidth-1:0] trial_in, rem_in;
      logic [RootWidth-1:0] rt_in;
      logic [SumWidth-1:0] rem_r;
      logic [RootWidth-1:0] rt_r;
      logic [MagWidth-1:0] rm_r [3];
      logic [2:0] rs_r;
      always_comb begin
         // (r + b)^2 - r^2 = 2rb + b^2
         trial_in = (SumWidth'(rt_ff[g]) << (Bit + 1)) + (SumWidth'(1) << (2 * Bit));
         if (rem_ff[g] >= trial_in) begin
            rem_in = rem_ff[g] - trial_in;
            rt_in  = rt_ff[g] | (RootWidth'(1) << Bit);
         end else begin
            rem_in = rem_ff[g];
            rt_in  = rt_ff[g];
         end
      end
      always_ff @(posedge clock) begin
         if (ctrl.advance) begin
            rem_r <= rem_in;
            rt_r  <= rt_in;
            rm_r  <= rm_ff[g];
            rs_r  <= rs_ff[g];
         end
      end
      assign rem_ff[g+1] = rem_r;
      assign rt_ff[g+1]  = rt_r;
      assign rm_ff[g+1]  = rm_r;
      assign rs_ff[g+1]  = rs_r;
   end

   assign root  = rt_ff[RootSteps];
   assign mag_x = rm_ff[RootSteps][0];
   assign mag_y = rm_ff[RootSteps][1];
   assign mag_z = rm_ff[RootSteps][2];
   assign neg   = rs_ff[RootSteps];
endmodule

FILE: hdl/tfn_scale.sv
module tfn_scale (
   input  logic                          clock,
   input  tfn_pkg::pipe_ctrl_type        ctrl,
   input  logic [tfn_pkg::EpsWidth-1:0]  epsilon,
   input  logic [tfn_pkg::RootWidth-1:0] root,
   input  logic [tfn_pkg::MagWidth-1:0]  mag_x,
   input  logic [tfn_pkg::MagWidth-1:0]  mag_y,
   input  logic [tfn_pkg::MagWidth-1:0]  mag_z,
   input  logic [2:0]                    neg,
   output tfn_pkg::rsp_item_type         result
);
   import tfn_pkg::*;

   localparam int RemWidth = RootWidth + 1;

   logic [NumWidth-1:0]  num_ff [DivSteps+1][3];
   logic [RemWidth-1:0]  rem_ff [DivSteps+1][3];
   logic [QuotWidth-1:0] quo_ff [DivSteps+1][3];
   logic [RootWidth-1:0] den_ff [DivSteps+1];
   logic [2:0]           neg_ff [DivSteps+1];
   logic                 dgn_ff [DivSteps+1];
   logic [MagWidth-1:0]  mags [3];
   rsp_item_type         result_ff, result_in;

   assign mags = '{mag_x, mag_y, mag_z};

   // Entry: numerator |n|*16384 + floor(L/2); degenerate check.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         num_ff[0][k] = (NumWidth'(mags[k]) << 14) + NumWidth'(root >> 1);
         rem_ff[0][k] = '0;
         quo_ff[0][k] = '0;
      end
      den_ff[0] = root;
      neg_ff[0] = neg;
      dgn_ff[0] = root <= RootWidth'(epsilon);
   end

   // Restoring division, one quotient bit per stage. The numerator is
   // below 2^15 * L, so the top bits shift in before the first compare.
   for (genvar g = 0; g < DivSteps; g++) begin : g_div
      localparam int Bit = DivSteps - 1 - g;
      logic [NumWidth-1:0]  num_r [3];
      logic [RemWidth-1:0]  rem_r [3];
      logic [QuotWidth-1:0] quo_r [3];
      logic [RootWidth-1:0] den_r;
      logic [2:0]           neg_r;
      logic                 dgn_r;
      logic [RemWidth-1:0]  rem_in [3];
      logic [QuotWidth-1:0] quo_in [3];
      always_comb begin
         for (int k = 0; k < 3; k++) begin
            logic [RemWidth:0] part;
            if (g == 0) begin
               part = (RemWidth+1)'(num_ff[g][k] >> Bit);
            end else begin
               part = {rem_ff[g][k], num_ff[g][k][Bit]};
            end
            if (part >= (RemWidth+1)'(den_ff[g])) begin
               rem_in[k] = RemWidth'(part - (RemWidth+1)'(den_ff[g]));
               quo_in[k] = quo_ff[g][k] | (QuotWidth'(1) << Bit);
            end else begin
               rem_in[k] = RemWidth'(part);
               quo_in[k] = quo_ff[g][k];
            end
         end
      end
      always_ff @(posedge clock) begin
         if (ctrl.advance) begin
            num_r <= num_ff[g];
            rem_r <= rem_in;
            quo_r <= quo_in;
            den_r <= den_ff[g];
            neg_r <= neg_ff[g];
            dgn_r <= dgn_ff[g];
         end
      end
      assign num_ff[g+1] = num_r;
      assign rem_ff[g+1] = rem_r;
      assign quo_ff[g+1] = quo_r;
      assign den_ff[g+1] = den_r;
      assign neg_ff[g+1] = neg_r;
      assign dgn_ff[g+1] = dgn_r;
   end

   // Clamp, apply sign and zero the degenerate case.
   always_comb begin
      logic [NormWidth-1:0] q [3];
      for (int k = 0; k < 3; k++) begin
         q[k] = NormWidth'(quo_ff[DivSteps][k]);
         if (q[k] > NormOne) begin
            q[k] = NormOne;
         end
         if (neg_ff[DivSteps][k]) begin
            q[k] = -q[k];
         end
         if (dgn_ff[DivSteps]) begin
            q[k] = '0;
         end
      end
      result_in.norm_x     = q[0];
      result_in.norm_y     = q[1];
      result_in.norm_z     = q[2];
      result_in.degenerate = dgn_ff[DivSteps];
   end

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;
endmodule

FILE: hdl/triangle_face_normal_unit.sv
// Stages from an accepted item to its result: cross product, sum of squares, one
// square root bit per stage, one quotient bit per stage, output register.
// Throughput: one item per cycle; the whole pipeline stalls only when the output
// holds a result that is not taken. Synchronous active high reset clears all
// valid bits and sets the epsilon register to 1.
module triangle_face_normal_unit (
   input  logic                               clock,
   input  logic                               reset,
   tfn_req_if.sink                            req,
   tfn_rsp_if.source                          rsp,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [tfn_pkg::CsrAddrWidth+1:0]   csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);
   import tfn_pkg::*;

   localparam int Depth = 3 + 4 + RootSteps + DivSteps + 1;

   logic [EpsWidth-1:0] eps_ff;
   logic [Depth-1:0]    valid_ff, valid_in;
   pipe_ctrl_type       ctrl;
   logic signed [CrossWidth-1:0] cx, cy, cz;
   logic [RootWidth-1:0] root;
   logic [MagWidth-1:0]  mx, my, mz;
   logic [2:0]           neg;
   logic                 csr_hit;

   // Configuration register.
   assign csr_pready = 1'b1;
   assign csr_hit = csr_paddr[CsrAddrWidth+1:2] == CSR_EPSILON && csr_paddr[1:0] == 2'b00;
   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= EpsilonReset;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_hit) begin
         eps_ff <= csr_pwdata[EpsWidth-1:0];
      end
   end
   assign csr_prdata = csr_hit ? 32'(eps_ff) : '0;

   // The whole pipe moves unless the output holds an untaken result.
   assign ctrl.advance = !valid_ff[Depth-1] || rsp.ready;
   assign req.ready = ctrl.advance;
   assign valid_in = {valid_ff[Depth-2:0], req.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ctrl.advance) begin
         valid_ff <= valid_in;
      end
   end

   tfn_cross u_cross (
      .clock(clock), .ctrl(ctrl), .item(req.item),
      .cross_x(cx), .cross_y(cy), .cross_z(cz)
   );

   tfn_sqrt u_sqrt (
      .clock(clock), .ctrl(ctrl), .cross_x(cx), .cross_y(cy), .cross_z(cz),
      .root(root), .mag_x(mx), .mag_y(my), .mag_z(mz), .neg(neg)
   );

   tfn_scale u_scale (
      .clock(clock), .ctrl(ctrl), .epsilon(eps_ff), .root(root),
      .mag_x(mx), .mag_y(my), .mag_z(mz), .neg(neg), .result(rsp.item)
   );

   assign rsp.valid = valid_ff[Depth-1];

   // A stalled result stays put.
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.item))
      else $error("result changed while stalled");

   // An accepted item shows up in the first valid bit.
   assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> valid_ff[0])
      else $error("accepted item lost");

   // A degenerate result carries the zero vector.
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.item.degenerate |->
      rsp.item.norm_x == '0 && rsp.item.norm_y == '0 && rsp.item.norm_z == '0)
      else $error("degenerate result not zero");
endmodule

FILE: tb/tb_normal_checker.sv
`timescale 1ns / 1ps

module tb_normal_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  tfn_pkg::req_item_type     req_item,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  tfn_pkg::rsp_item_type     rsp_item,
   input  logic                      eps_write,
   input  logic [15:0]               eps_value,
   output int                        fail_count,
   output int                        pending_count
);
   import tfn_pkg::*;

   logic [15:0]  epsilon;
   rsp_item_type expected_normals[$];
   int           mismatch_count;

   // Integer square root, floor, of a sum below 2^70.
   function automatic logic [34:0] root_floor(input logic [69:0] sum);
      logic [34:0] root;
      logic [34:0] trial;
      root = '0;
      for (int bit_index = 34; bit_index >= 0; bit_index--) begin
         trial = root | (35'd1 << bit_index);
         if ({35'd0, trial} * {35'd0, trial} <= sum) begin
            root = trial;
         end
      end
      return root;
   endfunction

   // One normal component, rounded half away from zero and clamped to one.
   function automatic logic [15:0] scale_axis(input longint n, input longint len);
      longint mag;
      longint q;
      mag = (n < 0) ? -n : n;
      q = (mag * 16384 + len / 2) / len;
      if (q > 16384) begin
         q = 16384;
      end
      return (n < 0) ? 16'(-q) : 16'(q);
   endfunction

   function automatic rsp_item_type predict_normal(input req_item_type t,
                                                   input logic [15:0] eps);
      longint e1x, e1y, e1z, e2x, e2y, e2z, nx, ny, nz;
      logic [69:0] sum;
      longint len;
      rsp_item_type r;
      e1x = longint'(t.b_x) - longint'(t.a_x);
      e1y = longint'(t.b_y) - longint'(t.a_y);
      e1z = longint'(t.b_z) - longint'(t.a_z);
      e2x = longint'(t.c_x) - longint'(t.a_x);
      e2y = longint'(t.c_y) - longint'(t.a_y);
      e2z = longint'(t.c_z) - longint'(t.a_z);
      nx = e1y * e2z - e1z * e2y;
      ny = e1z * e2x - e1x * e2z;
      nz = e1x * e2y - e1y * e2x;
      sum = 70'(nx < 0 ? -nx : nx) * 70'(nx < 0 ? -nx : nx)
          + 70'(ny < 0 ? -ny : ny) * 70'(ny < 0 ? -ny : ny)
          + 70'(nz < 0 ? -nz : nz) * 70'(nz < 0 ? -nz : nz);
      len = longint'(root_floor(sum));
      if (len <= longint'(eps)) begin
         r = '{norm_x: '0, norm_y: '0, norm_z: '0, degenerate: 1'b1};
      end else begin
         r.norm_x = scale_axis(nx, len);
         r.norm_y = scale_axis(ny, len);
         r.norm_z = scale_axis(nz, len);
         r.degenerate = 1'b0;
      end
      return r;
   endfunction

   assign fail_count = mismatch_count;
   assign pending_count = expected_normals.size();

   // Predict on accepted triangles, compare accepted normals in order.
   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         epsilon <= EpsilonReset;
         expected_normals.delete();
         mismatch_count <= 0;
      end else begin
         if (eps_write) begin
            epsilon <= eps_value;
         end
         if (req_valid && req_ready) begin
            expected_normals.push_back(predict_normal(req_item, epsilon));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_normals.size() == 0) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < 10) begin
                  $display("unexpected item: %p", rsp_item);
               end
            end else begin
               want = expected_normals.pop_front();
               if (want !== rsp_item) begin
                  mismatch_count <= mismatch_count + 1;
                  if (mismatch_count < 10) begin
                     $display("mismatch: expected %p, got %p", want, rsp_item);
                  end
               end
            end
         end
      end
   end
endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import tfn_pkg::*;

   localparam int CycleLimit = 400000;
   localparam int Latency = 58;

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          fail_count;
   int          pending_count;
   int          send_idle_pct;
   int          stall_pct;
   bit          hold_off;
   int          cycle_count;

   tfn_req_if req ();
   tfn_rsp_if rsp ();

   triangle_face_normal_unit dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   tb_normal_checker checker_inst (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready), .req_item(req.item),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_item(rsp.item),
      .eps_write(csr_psel && csr_penable && csr_pwrite && csr_pready
                 && csr_paddr == 3'(4 * CSR_EPSILON)),
      .eps_value(csr_pwdata[15:0]),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog.
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CycleLimit) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // Receiver: random stalls, plus a long hold-off when asked.
   initial begin
      rsp.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp.ready <= !hold_off && ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic write_epsilon(input logic [15:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= 3'(4 * CSR_EPSILON);
      csr_pwdata <= 32'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // Offer one triangle, with a random gap before it, until accepted.
   task automatic send_triangle(input req_item_type t);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.item <= t;
      @(posedge clock);
      while (!req.ready) begin
         @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) begin
         @(posedge clock);
      end
      repeat (Latency + 4) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_coord(input int mode);
      case (mode)
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'($urandom_range(255)) - 16'd128;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic req_item_type random_triangle();
      req_item_type t;
      int mode;
      mode = $urandom_range(9);
      t = req_item_type'({$urandom, $urandom, $urandom, $urandom, $urandom});
      if (mode < 2) begin
         // Collinear corners: c = a + 2(b - a) on the 16-bit wrap.
         t.c_x = 16'(2 * t.b_x - t.a_x);
         t.c_y = 16'(2 * t.b_y - t.a_y);
         t.c_z = 16'(2 * t.b_z - t.a_z);
      end else if (mode < 5) begin
         // Small triangle near a random corner, lengths near epsilon.
         t.b_x = t.a_x + pick_coord(2); t.b_y = t.a_y + pick_coord(2);
         t.b_z = t.a_z + pick_coord(2); t.c_x = t.a_x + pick_coord(2);
         t.c_y = t.a_y + pick_coord(2); t.c_z = t.a_z + pick_coord(2);
         if (mode == 4) begin
            t.b_x = t.a_x + 16'($urandom_range(3));
            t.c_y = t.a_y + 16'($urandom_range(3));
         end
      end else if (mode == 5) begin
         t = '{pick_coord($urandom_range(3)), pick_coord($urandom_range(3)),
               pick_coord($urandom_range(3)), pick_coord($urandom_range(3)),
               pick_coord($urandom_range(3)), pick_coord($urandom_range(3)),
               pick_coord($urandom_range(3)), pick_coord($urandom_range(3)),
               pick_coord($urandom_range(3))};
      end
      return t;
   endfunction

   initial begin
      logic [15:0] eps_settings[5];
      int idle_settings[4][2];
      int phase;
      eps_settings = '{16'd0, 16'd200, 16'd3, 16'hffff, 16'd1};
      idle_settings = '{'{0, 0}, '{55, 0}, '{0, 55}, '{26, 26}};
      reset = 1'b1;
      hold_off = 1'b0;
      send_idle_pct = 0;
      stall_pct = 0;
      req.valid = 1'b0;
      req.item = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset epsilon.
      send_triangle('0);
      send_triangle('{16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000,
                      16'h8000, 16'h7fff, 16'h8000});
      send_triangle('{16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff,
                      16'h7fff, 16'h8000, 16'h8000});
      send_triangle('{16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                      16'h7fff, 16'h7fff, 16'h8000});
      send_triangle('{16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h0000,
                      16'h0000, 16'h0001, 16'h0000});
      send_triangle('{16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h0000,
                      16'h0000, 16'h0002, 16'h0000});
      send_triangle('{16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'h0100, 16'h0000,
                      16'hff00, 16'h0100, 16'h0000});
      send_triangle('{16'h1234, 16'hfedc, 16'h0101, 16'h1234, 16'hfedc, 16'h0101,
                      16'h5555, 16'haaaa, 16'h7fff});
      wait_drained();

      // Random phases over epsilon and idling settings.
      for (phase = 0; phase < 10; phase++) begin
         write_epsilon(eps_settings[phase % 5]);
         send_idle_pct = idle_settings[phase % 4][0];
         stall_pct = idle_settings[phase % 4][1];
         if (phase == 0) begin
            send_triangle('0);
            send_triangle('{16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h0000,
                            16'h0000, 16'h0000, 16'h0001, 16'h0000});
         end
         if (phase == 2) begin
            // Long receiver hold-off while the sender keeps offering.
            fork
               begin
                  hold_off = 1'b1;
                  repeat (200) @(posedge clock);
                  hold_off = 1'b0;
               end
               repeat (120) send_triangle(random_triangle());
            join
         end else begin
            repeat (50) send_triangle(random_triangle());
         end
         wait_drained();
      end

      if (fail_count == 0 && pending_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule

FILE: filelist.f
hdl/tfn_pkg.sv
hdl/tfn_if.sv
hdl/tfn_cross.sv
hdl/tfn_sqrt.sv
hdl/tfn_scale.sv
hdl/triangle_face_normal_unit.sv
tb/tb_normal_checker.sv
tb/tb_top.sv
